### design/mf3_pkg.sv
`timescale 1ns / 1ps

package mf3_pkg;

	localparam int MAX_WIDTH_DEF    = 1024;
	localparam int MAX_HEIGHT_DEF   = 1024;
	localparam int PIXEL_BITS_DEF   = 8;

	localparam int PIX_W            = 8;
	localparam int COORD_W          = 10;

	localparam int CFG_IDX_W        = 1;
	localparam int CFG_DATA_W       = 11;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
	localparam int FRAME_SIZE_RESET = 1024;

	localparam int QUEUE_DEPTH      = 4;

	// which results one input pixel causes, in output order win, tail, bottom
	typedef struct packed {
		logic bottom;
		logic tail;
		logic win;
	} mf3_emit_t;

	typedef struct packed {
		mf3_emit_t emit;
		logic      interior;
		logic      end_row;
	} mf3_job_flags_t;

endpackage

### design/mf3_pix_if.sv
`timescale 1ns / 1ps

interface mf3_pix_if
	import mf3_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

### design/mf3_res_if.sv
`timescale 1ns / 1ps

interface mf3_res_if
	import mf3_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [PIX_W-1:0]   pixel_out;
	logic [COORD_W-1:0] out_row;
	logic [COORD_W-1:0] out_col;
	logic               run_last;
	logic               frame_last;

	modport source (output valid, output pixel_out, output out_row, output out_col,
		output run_last, output frame_last, input ready);
	modport sink (input valid, input pixel_out, input out_row, input out_col,
		input run_last, input frame_last, output ready);
endinterface

### design/mean_filter_3x3_stream.sv
`timescale 1ns / 1ps

// channel   dir  transfer                    payload
// pixels    in   pixels.valid & ready        pixel_in
// results   out  results.valid & ready       pixel_out out_row out_col run_last frame_last
// cfg       in   cfg_wr_en                   cfg_index cfg_wdata
//
// one pixel accepted per cycle while the queue has room; the output side moves one result
// per cycle while results.ready is high, so a pixel with two or three results holds the
// result port until all of them have moved; an idle pipe raises the first result once
// the pixel has passed front stage, queue, divide-by-nine multiply and output register
// the queue lets the front run on while the result side is stalled
// reset clears position counters, window sums and all valid flags; line rams hold
// no reset, so the first rows after reset read entries not yet written

module mean_filter_3x3_stream
	import mf3_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	mf3_pix_if.sink               pixels,
	mf3_res_if.source             results,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int PB    = PIXEL_BITS;
	localparam int SUM_W = PB + 4;
	localparam int WSZ_W = (CFG_DATA_W > CW + 1) ? CFG_DATA_W : CW + 1;
	localparam int HSZ_W = (CFG_DATA_W > RW + 1) ? CFG_DATA_W : RW + 1;
	localparam int RST_W = (FRAME_SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_SIZE_RESET;
	localparam int RST_H = (FRAME_SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_SIZE_RESET;
	localparam int JOB_W = $bits(mf3_job_flags_t) + SUM_W + 3 * PB + RW + CW;

	logic [CW-1:0]    wm1_q;
	logic [RW-1:0]    hm1_q;
	logic [WSZ_W-1:0] w_ext;
	logic [HSZ_W-1:0] h_ext;
	logic [CW-1:0]    wm1_d;
	logic [RW-1:0]    hm1_d;

	assign w_ext = WSZ_W'(cfg_wdata);
	assign h_ext = HSZ_W'(cfg_wdata);

	// zero counts as one, sizes above the maximum saturate
	always_comb begin
		if (w_ext == '0) begin
			wm1_d = '0;
		end else if (w_ext > WSZ_W'(MAX_WIDTH)) begin
			wm1_d = CW'(MAX_WIDTH - 1);
		end else begin
			wm1_d = CW'(w_ext - 1'b1);
		end
		if (h_ext == '0) begin
			hm1_d = '0;
		end else if (h_ext > HSZ_W'(MAX_HEIGHT)) begin
			hm1_d = RW'(MAX_HEIGHT - 1);
		end else begin
			hm1_d = RW'(h_ext - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q <= CW'(RST_W - 1);
			hm1_q <= RW'(RST_H - 1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH: begin
					wm1_q <= wm1_d;
				end
				REG_FRAME_HEIGHT: begin
					hm1_q <= hm1_d;
				end
				default: begin
				end
			endcase
		end
	end

	logic             f_valid;
	logic             f_ready;
	mf3_job_flags_t   f_flags;
	logic [SUM_W-1:0] f_sum;
	logic [PB-1:0]    f_center;
	logic [PB-1:0]    f_tail;
	logic [PB-1:0]    f_pix;
	logic [RW-1:0]    f_row;
	logic [CW-1:0]    f_col;

	logic             b_valid;
	logic             b_ready;
	logic [JOB_W-1:0] b_job;
	mf3_job_flags_t   b_flags;
	logic [SUM_W-1:0] b_sum;
	logic [PB-1:0]    b_center;
	logic [PB-1:0]    b_tail;
	logic [PB-1:0]    b_pix;
	logic [RW-1:0]    b_row;
	logic [CW-1:0]    b_col;

	mf3_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.PIXEL_BITS (PIXEL_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.wm1        (wm1_q),
		.hm1        (hm1_q),
		.in_valid   (pixels.valid),
		.in_ready   (pixels.ready),
		.pixel_in   (pixels.pixel_in),
		.job_valid  (f_valid),
		.job_ready  (f_ready),
		.job_flags  (f_flags),
		.job_sum    (f_sum),
		.job_center (f_center),
		.job_tail   (f_tail),
		.job_pix    (f_pix),
		.job_row    (f_row),
		.job_col    (f_col)
	);

	mf3_queue #(
		.WIDTH (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  ({f_flags, f_sum, f_center, f_tail, f_pix, f_row, f_col}),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_job)
	);

	assign {b_flags, b_sum, b_center, b_tail, b_pix, b_row, b_col} = b_job;

	mf3_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.PIXEL_BITS (PIXEL_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (b_valid),
		.job_ready  (b_ready),
		.job_flags  (b_flags),
		.job_sum    (b_sum),
		.job_center (b_center),
		.job_tail   (b_tail),
		.job_pix    (b_pix),
		.job_row    (b_row),
		.job_col    (b_col),
		.res_valid  (results.valid),
		.res_ready  (results.ready),
		.pixel_out  (results.pixel_out),
		.out_row    (results.out_row),
		.out_col    (results.out_col),
		.run_last   (results.run_last),
		.frame_last (results.frame_last)
	);

endmodule

### design/mf3_ram.sv
`timescale 1ns / 1ps

module mf3_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/mf3_queue.sv
`timescale 1ns / 1ps

module mf3_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill count past depth");

endmodule

### design/mf3_front.sv
`timescale 1ns / 1ps

module mf3_front
	import mf3_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [$clog2(MAX_WIDTH)-1:0]  wm1,
	input  logic [$clog2(MAX_HEIGHT)-1:0] hm1,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [PIX_W-1:0]              pixel_in,
	output logic                          job_valid,
	input  logic                          job_ready,
	output mf3_job_flags_t                job_flags,
	output logic [PIXEL_BITS+3:0]         job_sum,
	output logic [PIXEL_BITS-1:0]         job_center,
	output logic [PIXEL_BITS-1:0]         job_tail,
	output logic [PIXEL_BITS-1:0]         job_pix,
	output logic [$clog2(MAX_HEIGHT)-1:0] job_row,
	output logic [$clog2(MAX_WIDTH)-1:0]  job_col
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int PB    = PIXEL_BITS;
	localparam int COL_W = PB + 2;
	localparam int SUM_W = PB + 4;

	logic [CW-1:0]      col_q;
	logic [RW-1:0]      row_q;
	logic               accept;
	logic               advance;
	logic               end_row;
	logic               last_row;
	mf3_job_flags_t     flags_d;

	logic               valid_s1;
	logic [PB-1:0]      pix_s1;
	logic [RW-1:0]      row_s1;
	logic [CW-1:0]      col_s1;
	mf3_job_flags_t     flags_s1;
	logic               fwd_s1;
	logic [2*PB-1:0]    fwd_data_s1;

	logic [2*PB-1:0]    ram_rdata;
	logic [2*PB-1:0]    line_pair;
	logic [PB-1:0]      older_px;
	logic [PB-1:0]      newer_px;
	logic [COL_W-1:0]   colsum_new;
	logic [COL_W-1:0]   colsum_a_q;
	logic [COL_W-1:0]   colsum_b_q;
	logic [PB-1:0]      newer_prev_q;

	assign advance  = valid_s1 && job_ready;
	assign in_ready = !valid_s1 || job_ready;
	assign accept   = in_valid && in_ready;

	assign end_row  = (col_q >= wm1);
	assign last_row = (row_q >= hm1);

	always_comb begin
		flags_d             = '0;
		flags_d.emit.win    = (row_q != '0) && (col_q != '0);
		flags_d.emit.tail   = (row_q != '0) && end_row;
		flags_d.emit.bottom = last_row;
		flags_d.interior    = (row_q >= RW'(2)) && (row_q <= hm1)
			&& (col_q >= CW'(2)) && (col_q <= wm1);
		flags_d.end_row     = end_row;
	end

	// raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (end_row) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// one entry per column: {older row, newer row}
	mf3_ram #(
		.WIDTH (2 * PB),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (advance),
		.waddr (col_s1),
		.wdata ({newer_px, pix_s1}),
		.re    (accept),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				// the transfer leaving now writes the column being read
				fwd_s1   <= advance && (col_s1 == col_q);
			end else if (advance) begin
				valid_s1 <= 1'b0;
				fwd_s1   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= PB'(pixel_in);
			row_s1      <= row_q;
			col_s1      <= col_q;
			flags_s1    <= flags_d;
			fwd_data_s1 <= {newer_px, pix_s1};
		end
	end

	assign line_pair  = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign older_px   = line_pair[2*PB-1:PB];
	assign newer_px   = line_pair[PB-1:0];
	assign colsum_new = COL_W'(older_px) + COL_W'(newer_px) + COL_W'(pix_s1);

	// window kept as two column sums plus the middle-row centre pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colsum_a_q   <= '0;
			colsum_b_q   <= '0;
			newer_prev_q <= '0;
		end else if (advance) begin
			colsum_a_q   <= colsum_b_q;
			colsum_b_q   <= colsum_new;
			newer_prev_q <= newer_px;
		end
	end

	assign job_valid  = valid_s1;
	assign job_flags  = flags_s1;
	assign job_sum    = SUM_W'(colsum_a_q) + SUM_W'(colsum_b_q) + SUM_W'(colsum_new);
	assign job_center = newer_prev_q;
	assign job_tail   = newer_px;
	assign job_pix    = pix_s1;
	assign job_row    = row_s1;
	assign job_col    = col_s1;

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_row |=> col_q == '0)
		else $error("column counter did not wrap at row end");

	a_fwd_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> valid_s1)
		else $error("line forward flagged with empty stage");

endmodule

### design/mf3_back.sv
`timescale 1ns / 1ps

module mf3_back
	import mf3_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	output logic                          job_ready,
	input  mf3_job_flags_t                job_flags,
	input  logic [PIXEL_BITS+3:0]         job_sum,
	input  logic [PIXEL_BITS-1:0]         job_center,
	input  logic [PIXEL_BITS-1:0]         job_tail,
	input  logic [PIXEL_BITS-1:0]         job_pix,
	input  logic [$clog2(MAX_HEIGHT)-1:0] job_row,
	input  logic [$clog2(MAX_WIDTH)-1:0]  job_col,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [PIX_W-1:0]              pixel_out,
	output logic [COORD_W-1:0]            out_row,
	output logic [COORD_W-1:0]            out_col,
	output logic                          run_last,
	output logic                          frame_last
);

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int RW     = $clog2(MAX_HEIGHT);
	localparam int PB     = PIXEL_BITS;
	localparam int SUM_W  = PB + 4;
	localparam int SHIFT  = SUM_W + 4;
	localparam int MUL_W  = SHIFT - 2;
	localparam int PROD_W = SUM_W + MUL_W;
	// ceil(2^SHIFT / 9): exact quotient for every sum of SUM_W bits
	localparam logic [MUL_W-1:0] RECIP = MUL_W'(((64'd1 << SHIFT) + 64'd8) / 64'd9);

	logic              valid_s2;
	mf3_emit_t         pend_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [PB-1:0]     center_s2;
	logic [PB-1:0]     tail_s2;
	logic [PB-1:0]     pix_s2;
	logic [RW-1:0]     row_s2;
	logic [CW-1:0]     col_s2;
	logic              interior_s2;
	logic              end_row_s2;

	logic              valid_s3;
	logic [PIX_W-1:0]  pixel_s3;
	logic [COORD_W-1:0] row_s3;
	logic [COORD_W-1:0] col_s3;
	logic              run_last_s3;
	logic              frame_last_s3;

	logic              out_free;
	logic              emit_now;
	logic              done;
	logic              load;
	mf3_emit_t         sel;
	mf3_emit_t         pend_next;
	logic [PB-1:0]     quot;
	logic [PB-1:0]     val;
	logic [RW-1:0]     row_val;
	logic [CW-1:0]     col_val;
	logic              flast_val;

	assign out_free  = !valid_s3 || res_ready;
	assign emit_now  = valid_s2 && out_free;

	always_comb begin
		sel = '0;
		if (pend_s2.win) begin
			sel.win = 1'b1;
		end else if (pend_s2.tail) begin
			sel.tail = 1'b1;
		end else begin
			sel.bottom = pend_s2.bottom;
		end
	end

	assign pend_next = pend_s2 & ~sel;
	assign done      = emit_now && (pend_next == '0);
	assign job_ready = !valid_s2 || done;
	assign load      = job_valid && job_ready && (job_flags.emit != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			pend_s2  <= '0;
		end else begin
			if (load) begin
				valid_s2 <= 1'b1;
				pend_s2  <= job_flags.emit;
			end else if (done) begin
				valid_s2 <= 1'b0;
				pend_s2  <= '0;
			end else if (emit_now) begin
				pend_s2  <= pend_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s2     <= PROD_W'(job_sum) * PROD_W'(RECIP);
			center_s2   <= job_center;
			tail_s2     <= job_tail;
			pix_s2      <= job_pix;
			row_s2      <= job_row;
			col_s2      <= job_col;
			interior_s2 <= job_flags.interior;
			end_row_s2  <= job_flags.end_row;
		end
	end

	assign quot = PB'(prod_s2 >> SHIFT);

	always_comb begin
		val       = pix_s2;
		row_val   = row_s2;
		col_val   = col_s2;
		flast_val = 1'b0;
		if (sel.win) begin
			val     = interior_s2 ? quot : center_s2;
			row_val = row_s2 - 1'b1;
			col_val = col_s2 - 1'b1;
		end else if (sel.tail) begin
			val     = tail_s2;
			row_val = row_s2 - 1'b1;
		end else begin
			flast_val = end_row_s2;
		end
	end

	// output register parts the result side from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (out_free) begin
			valid_s3 <= emit_now;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_now) begin
			pixel_s3      <= PIX_W'(val);
			row_s3        <= COORD_W'(row_val);
			col_s3        <= COORD_W'(col_val);
			run_last_s3   <= (pend_next == '0);
			frame_last_s3 <= flast_val;
		end
	end

	assign res_valid  = valid_s3;
	assign pixel_out  = pixel_s3;
	assign out_row    = row_s3;
	assign out_col    = col_s3;
	assign run_last   = run_last_s3;
	assign frame_last = frame_last_s3;

	a_busy_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> pend_s2 != '0)
		else $error("sequencer busy with nothing pending");

	a_frame_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && frame_last_s3 |-> run_last_s3)
		else $error("frame end not last result of its pixel");

endmodule
